// ----- sv/iral_pkg.sv -----
// Package with the shared types and constants of the address range lookup table.
`timescale 1ns / 1ps
package iral_pkg;

  typedef enum logic [2:0] {
    ST_OK              = 3'd0,
    ST_NOT_FOUND       = 3'd1,
    ST_START_ABOVE_END = 3'd2,
    ST_ZERO_NUMBER     = 3'd3,
    ST_OVERLAP         = 3'd4,
    ST_FULL            = 3'd5
  } status_e;

  localparam logic ACT_ADD    = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;

  typedef struct packed {
    logic          action;
    logic [127:0]  range_start;
    logic [127:0]  range_end;
    logic [31:0]   range_number;
    logic [127:0]  query_addr;
  } req_t;

  // Classified job handed from the front part to the back part.
  typedef struct packed {
    logic          lookup;
    logic          rejected;
    status_e       early_status;
    logic [127:0]  lo_key;
    logic [127:0]  hi_key;
    logic [31:0]   number;
  } job_t;

  typedef struct packed {
    logic [31:0]   found_number;
    status_e       status;
  } res_t;

endpackage

// ----- sv/iral_if.sv -----
// Valid/ready channel interfaces for requests and results.
`timescale 1ns / 1ps
interface iral_req_if;
  logic                 valid;
  logic                 ready;
  logic                 action;
  logic [63:0]          range_start_hi;
  logic [63:0]          range_start_lo;
  logic [63:0]          range_end_hi;
  logic [63:0]          range_end_lo;
  logic [31:0]          range_number;
  logic [63:0]          query_addr_hi;
  logic [63:0]          query_addr_lo;
  modport source (output valid, action, range_start_hi, range_start_lo, range_end_hi,
                  range_end_lo, range_number, query_addr_hi, query_addr_lo, input ready);
  modport sink (input valid, action, range_start_hi, range_start_lo, range_end_hi,
                range_end_lo, range_number, query_addr_hi, query_addr_lo, output ready);
endinterface

interface iral_res_if;
  logic        valid;
  logic        ready;
  logic [31:0] found_number;
  logic [2:0]  status;
  modport source (output valid, found_number, status, input ready);
  modport sink (input valid, found_number, status, output ready);
endinterface

// ----- sv/ip_range_asn_lookup_top.sv -----
// Top level of the address range lookup table.
`timescale 1ns / 1ps
// Each request beat is checked on entry and queued; the back part then scans the stored
// ranges one entry at a time through the registered read port of the range memory, each
// entry passing a read state and then a compare state, ending early at the first hit.
// Rejected adds skip the scan. The table is empty after reset with no clearing pass, as a
// fill count marks the valid entries.
module ip_range_asn_lookup_top #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  iral_req_if.sink   req,
  iral_res_if.source res
);
  import iral_pkg::*;

  logic job_valid, job_ready;
  job_t job;

  iral_front u_front (
    .clk_i, .rst_ni, .req,
    .job_valid_o(job_valid), .job_ready_i(job_ready), .job_o(job));

  iral_back #(.TableDepth(TABLE_DEPTH)) u_back (
    .clk_i, .rst_ni,
    .job_valid_i(job_valid), .job_ready_o(job_ready), .job_i(job), .res);
endmodule

// ----- sv/iral_ram.sv -----
// Generic RAM with one write port and one registered read port.
`timescale 1ns / 1ps
module iral_ram #(
  parameter int Width = 32,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

// ----- sv/iral_front.sv -----
// Front part: accepts request beats, runs the early checks and queues jobs.
`timescale 1ns / 1ps
module iral_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  iral_req_if.sink            req,
  output logic                job_valid_o,
  input  logic                job_ready_i,
  output iral_pkg::job_t      job_o
);
  import iral_pkg::*;

  localparam int QDepth = 2;

  job_t        q_mem [QDepth];
  logic        wptr_q, wptr_d, rptr_q, rptr_d;
  logic [1:0]  cnt_q, cnt_d;
  job_t        job_new;
  logic        push, pop;

  // Classify the incoming beat.
  always_comb begin
    logic [127:0] s, e;
    s = {req.range_start_hi, req.range_start_lo};
    e = {req.range_end_hi, req.range_end_lo};
    job_new = '0;
    job_new.number = req.range_number;
    if (req.action == ACT_LOOKUP) begin
      job_new.lookup = 1'b1;
      job_new.lo_key = {req.query_addr_hi, req.query_addr_lo};
      job_new.hi_key = {req.query_addr_hi, req.query_addr_lo};
      job_new.early_status = ST_NOT_FOUND;
    end else begin
      job_new.lo_key = s;
      job_new.hi_key = e;
      if (s > e) begin
        job_new.rejected = 1'b1;
        job_new.early_status = ST_START_ABOVE_END;
      end else if (req.range_number == '0) begin
        job_new.rejected = 1'b1;
        job_new.early_status = ST_ZERO_NUMBER;
      end else begin
        job_new.early_status = ST_OK;
      end
    end
  end

  assign req.ready   = (cnt_q != 2'(QDepth));
  assign push        = req.valid && req.ready;
  assign job_valid_o = (cnt_q != '0);
  assign pop         = job_valid_o && job_ready_i;
  assign job_o       = q_mem[rptr_q];

  // Queue pointers.
  always_comb begin
    wptr_d = push ? ~wptr_q : wptr_q;
    rptr_d = pop ? ~rptr_q : rptr_q;
    cnt_d  = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wptr_q] <= job_new;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'(QDepth)) else $error("queue overfilled");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'(QDepth)) |-> !push) else $error("push into full queue");
  a_valid_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_o == (cnt_q != '0)) else $error("valid does not track occupancy");
endmodule

// ----- sv/iral_back.sv -----
// Back part: scans stored ranges one entry at a time, writes new ranges, and takes one job at a time.
`timescale 1ns / 1ps
module iral_back #(
  parameter int TableDepth = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              job_valid_i,
  output logic              job_ready_o,
  input  iral_pkg::job_t    job_i,
  iral_res_if.source        res
);
  import iral_pkg::*;

  localparam int AW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int CW = $clog2(TableDepth + 1);
  localparam int RamDepth = 2 ** AW;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_READ  = 4'b0010,
    S_CMP   = 4'b0100,
    S_OUT   = 4'b1000
  } state_e;

  state_e        state_q, state_d;
  job_t          job_q;
  logic [CW-1:0] used_q, used_d;
  logic [CW-1:0] idx_q, idx_d;
  logic          ovalid_q, ovalid_d;
  res_t          ores_q, ores_d;
  logic [127:0]  rd_start, rd_end;
  logic [31:0]   rd_num;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic          hit;
  logic          take;

  assign take = (state_q == S_IDLE) && job_valid_i && !ovalid_q;
  assign job_ready_o = (state_q == S_IDLE) && !ovalid_q;
  assign raddr = idx_q[AW-1:0];
  assign waddr = used_q[AW-1:0];

  iral_ram #(.Width(128), .Depth(RamDepth)) u_start (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(job_q.lo_key),
    .raddr_i(raddr), .rdata_o(rd_start));
  iral_ram #(.Width(128), .Depth(RamDepth)) u_end (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(job_q.hi_key),
    .raddr_i(raddr), .rdata_o(rd_end));
  iral_ram #(.Width(32), .Depth(RamDepth)) u_num (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(job_q.number),
    .raddr_i(raddr), .rdata_o(rd_num));

  // Entry match: for a lookup both keys are the address.
  assign hit = (job_q.lo_key <= rd_end) && (rd_start <= job_q.hi_key);

  // Scan sequencer.
  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    used_d   = used_q;
    ovalid_d = ovalid_q;
    ores_d   = ores_q;
    we       = 1'b0;
    if (ovalid_q && res.ready) begin
      ovalid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (take) begin
          idx_d   = '0;
          state_d = S_READ;
        end
      end
      S_READ: begin
        priority if (job_q.rejected) begin
          ores_d  = '{found_number: '0, status: job_q.early_status};
          state_d = S_OUT;
        end else if (idx_q >= used_q) begin
          if (job_q.lookup) begin
            ores_d = '{found_number: '0, status: ST_NOT_FOUND};
          end else if (used_q >= CW'(TableDepth)) begin
            ores_d = '{found_number: '0, status: ST_FULL};
          end else begin
            ores_d = '{found_number: '0, status: ST_OK};
            we     = 1'b1;
            used_d = used_q + CW'(1);
          end
          state_d = S_OUT;
        end else begin
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        if (hit) begin
          ores_d = job_q.lookup ? res_t'{found_number: rd_num, status: ST_OK}
                                : res_t'{found_number: '0, status: ST_OVERLAP};
          state_d = S_OUT;
        end else begin
          idx_d   = idx_q + CW'(1);
          state_d = S_READ;
        end
      end
      S_OUT: begin
        ovalid_d = 1'b1;
        state_d  = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      used_q   <= '0;
      idx_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      used_q   <= used_d;
      idx_q    <= idx_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      job_q <= job_i;
    end
    ores_q <= ores_d;
  end

  assign res.valid        = ovalid_q;
  assign res.found_number = ores_q.found_number;
  assign res.status       = ores_q.status;

  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("state not one-hot");
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CW'(TableDepth)) else $error("fill count beyond depth");
  a_write_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |=> (used_q == $past(used_q) + CW'(1))) else $error("write without count");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && !res.ready) |=> $stable(ores_q)) else $error("result changed");
endmodule
